[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Short forms for the concurrent assertions of the histogram checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[src/glh_pkg.sv]
// ----------------------------------------------------------------------------
// glh_pkg
// Types and constants shared by the gray-level histogram unit and its checker.
// ----------------------------------------------------------------------------
package glh_pkg;

    localparam int NUM_BINS           = 256;
    localparam int BIN_BITS           = 8;
    localparam int CHAN_BITS          = 8;
    localparam int GRAY_SHIFT         = 3;
    localparam int SUM_BITS           = 11;
    localparam int OUT_COUNT_BITS     = 20;
    localparam int COUNT_BITS_DEFAULT = 20;
    localparam int GRAY_MAX           = 191;

    typedef logic [1:0] cmd_t;

    localparam cmd_t CMD_PIXEL = 2'd0;
    localparam cmd_t CMD_READ  = 2'd1;
    localparam cmd_t CMD_CLEAR = 2'd2;

    typedef struct packed {
        cmd_t                 cmd;
        logic [CHAN_BITS-1:0] red;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] blue;
        logic [BIN_BITS-1:0]  bin_index;
    } glh_req_t;

    typedef struct packed {
        logic [BIN_BITS-1:0]       gray_level;
        logic [OUT_COUNT_BITS-1:0] bin_count;
        logic                      saturated;
    } glh_rsp_t;

endpackage

[src/glh_ram.sv]
// ----------------------------------------------------------------------------
// glh_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module glh_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/gray_level_histogram_unit.sv]
// ----------------------------------------------------------------------------
// gray_level_histogram_unit
// 256-bin histogram of gray levels computed from RGB pixels, with saturating
// bin counts, a bin read-back command and a clear command for all bins.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake            | Payload    | Contents
//  --------+----------------------+------------+-------------------------------
//  request | req_valid, req_ready | req        | cmd, red, green, blue, bin_index
//  result  | rsp_valid, rsp_ready | rsp        | gray_level, bin_count, saturated
//
//  One request transaction is accepted every cycle unless req_ready is low;
//  each yields one result transaction, registered first in the update stage
//  together with the registered read of the bin memory, then in the result register.
//  Reset (rst_n, asynchronous, active low) empties the pipeline and marks all
//  bins empty at once, so no clearing pass is needed; a clear command does the
//  same. A stalled result holds the update stage, and req_ready drops only while
//  both the update stage and result register are full and rsp_ready is low.
//
module gray_level_histogram_unit
    import glh_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  glh_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output glh_rsp_t rsp
);

    // Width used to view the count when it is cut to the result field.
    localparam int VIEW_BITS = (COUNT_BITS > OUT_COUNT_BITS) ? COUNT_BITS : OUT_COUNT_BITS;

    // ------------------------------------------------------------------------
    // Request side: gray level and bin address, computed before the RAM read.
    // ------------------------------------------------------------------------
    logic                req_fire;
    logic [SUM_BITS-1:0] weighted_sum;
    logic [BIN_BITS-1:0] req_gray;
    logic [BIN_BITS-1:0] req_idx;

    // 2R + 3G + B fits in eleven bits; the shift by three leaves eight.
    assign weighted_sum = (SUM_BITS'(req.red) << 1)
                        + (SUM_BITS'(req.green) << 1) + SUM_BITS'(req.green)
                        + SUM_BITS'(req.blue);
    assign req_gray     = weighted_sum[SUM_BITS-1:GRAY_SHIFT];
    assign req_idx      = (req.cmd == CMD_READ) ? req.bin_index : req_gray;
    assign req_fire     = req_valid && req_ready;

    // ------------------------------------------------------------------------
    // Update stage registers. The RAM read data lines up with this stage.
    // ------------------------------------------------------------------------
    logic                  s1_valid_reg, s1_valid_next;
    cmd_t                  s1_cmd_reg;
    logic [BIN_BITS-1:0]   s1_idx_reg;
    logic [BIN_BITS-1:0]   s1_gray_reg;
    logic                  fwd_hit_reg, fwd_hit_next;
    logic [COUNT_BITS-1:0] fwd_data_reg;
    logic [NUM_BINS-1:0]   bin_valid_reg, bin_valid_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    glh_rsp_t              rsp_reg, rsp_next;

    logic                  s1_adv;
    logic                  wr_en;
    logic [COUNT_BITS-1:0] ram_rd_data;
    logic [COUNT_BITS-1:0] base_count;
    logic [COUNT_BITS-1:0] new_count;
    logic [COUNT_BITS-1:0] shown_count;
    logic [VIEW_BITS-1:0]  count_view;
    logic                  count_full;

    // The update stage moves on whenever the result register is free or
    // being emptied; a new request can enter behind it in the same cycle.
    assign s1_adv    = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || s1_adv;
    assign wr_en     = s1_adv && (s1_cmd_reg == CMD_PIXEL);

    glh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_BINS)
    ) u_bin_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_idx_reg),
        .wr_data (new_count),
        .rd_en   (req_fire),
        .rd_addr (req_idx),
        .rd_data (ram_rd_data)
    );

    // The RAM returns old data when the bin being read is written in the same
    // cycle, so that write is captured and replaces the read data later.
    // A bin whose valid bit is clear reads as zero, which is how reset and the
    // clear command empty the histogram without touching the RAM.
    always_comb
    begin
        if (fwd_hit_reg)
        begin
            base_count = fwd_data_reg;
        end
        else if (bin_valid_reg[s1_idx_reg])
        begin
            base_count = ram_rd_data;
        end
        else
        begin
            base_count = '0;
        end
        count_full = (base_count == {COUNT_BITS{1'b1}});
        new_count  = count_full ? base_count : base_count + COUNT_BITS'(1);
    end

    always_comb
    begin
        shown_count = '0;
        rsp_next    = '0;
        case (s1_cmd_reg)
            CMD_PIXEL:
            begin
                shown_count         = new_count;
                rsp_next.gray_level = s1_gray_reg;
            end
            CMD_READ:
            begin
                shown_count = base_count;
            end
            default:
            begin
                shown_count = '0;
            end
        endcase
        count_view         = VIEW_BITS'(shown_count);
        rsp_next.bin_count = count_view[OUT_COUNT_BITS-1:0];
        rsp_next.saturated = (s1_cmd_reg inside {CMD_PIXEL, CMD_READ})
                             && (shown_count == {COUNT_BITS{1'b1}});
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        fwd_hit_next   = fwd_hit_reg;
        bin_valid_next = bin_valid_reg;
        rsp_valid_next = rsp_valid_reg;

        if (s1_adv && (s1_cmd_reg == CMD_CLEAR))
        begin
            bin_valid_next = '0;
        end
        else if (wr_en)
        begin
            bin_valid_next[s1_idx_reg] = 1'b1;
        end

        if (req_fire)
        begin
            s1_valid_next = 1'b1;
            fwd_hit_next  = wr_en && (s1_idx_reg == req_idx);
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        if (s1_adv)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            bin_valid_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            fwd_hit_reg   <= fwd_hit_next;
            bin_valid_reg <= bin_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_cmd_reg   <= req.cmd;
            s1_idx_reg   <= req_idx;
            s1_gray_reg  <= (req.cmd == CMD_PIXEL) ? req_gray : '0;
            fwd_data_reg <= new_count;
        end
        if (s1_adv)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[src/glh_checker.sv]
// ----------------------------------------------------------------------------
// glh_checker
// Port-level assertions for the gray-level histogram unit, bound to its top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module glh_checker
    import glh_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_ready,
    input glh_req_t req,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input glh_rsp_t rsp
);

    // A full count as it appears in the result field.
    localparam logic [OUT_COUNT_BITS-1:0] FULL_VIEW = (COUNT_BITS >= OUT_COUNT_BITS)
        ? {OUT_COUNT_BITS{1'b1}}
        : OUT_COUNT_BITS'((64'd1 << COUNT_BITS) - 64'd1);
    localparam logic NARROW = (COUNT_BITS <= OUT_COUNT_BITS);

    logic req_seen;
    assign req_seen = req_valid && (req.cmd != CMD_PIXEL || req.bin_index == req.bin_index);

    // A stalled result holds its contents.
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

    // With no result pending, the unit always takes a request.
    `ASSERT_IMPLY(a_ready_when_empty, clk, rst_n, !rsp_valid, req_ready || !req_seen)

    // The gray level never exceeds its range.
    `ASSERT_IMPLY(a_gray_range, clk, rst_n, rsp_valid, rsp.gray_level <= BIN_BITS'(GRAY_MAX))

    // The saturation flag only comes with a full count.
    `ASSERT_IMPLY(a_sat_count, clk, rst_n, rsp_valid && rsp.saturated, rsp.bin_count == FULL_VIEW)

    // When the count fits the result field, a pixel with a nonzero gray level always leaves a nonzero count.
    `ASSERT_IMPLY(a_pixel_count, clk, rst_n, NARROW && rsp_valid && rsp.gray_level != '0,
        rsp.bin_count != '0)

endmodule

bind gray_level_histogram_unit glh_checker #(
    .COUNT_BITS (COUNT_BITS)
) u_glh_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
